/* src/htqp_pkg.sv */
// Package for the quadratic-probe hash table: sizes, operation, bucket and
// status codes, and the command/status structs between controller and datapath.
// No dependencies.
package htqp_pkg;

  localparam int TABLE_SIZE  = 1024;
  localparam int IDX_W       = $clog2(TABLE_SIZE);
  localparam int HALF_SIZE   = TABLE_SIZE / 2;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int HASH_W      = 32;
  localparam int COUNT_W     = IDX_W + 1;
  localparam int OUT_COUNT_W = 10;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;

  localparam logic [1:0] BKT_EMPTY = 2'd0;
  localparam logic [1:0] BKT_USED  = 2'd1;
  localparam logic [1:0] BKT_TOMB  = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic clear;
    logic load;
    logic probe;
    logic commit;
  } htqp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic probe_stop;
    logic op_nop;
  } htqp_sts_t;

endpackage

/* src/hash_table_quadratic_probe_unit.sv */
// Top level of the quadratic-probe hash table: controller plus datapath.
// Uses htqp_pkg, htqp_ctrl and htqp_datapath.
//
// Open-addressing key/value table of TABLE_SIZE buckets with triangular
// probing from the low bits of hash_index. After reset a clearing pass over
// all TABLE_SIZE buckets empties the bucket status store; no item is taken
// until it ends. One item is worked at a time: an insert, lookup or remove
// probes p buckets (1 to TABLE_SIZE), one probe per cycle through the single
// read port of the bucket memories, then commits its result, waiting while an
// earlier result is still stalled in the output register; an unused kind goes
// straight to its commit. After the commit the controller returns to idle,
// where the next item is taken. The next item is accepted while a finished
// result waits in the output register.
module hash_table_quadratic_probe_unit import htqp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             kind,
  input  logic [KEY_WIDTH-1:0]   item_key,
  input  logic [HASH_W-1:0]      hash_index,
  input  logic [VALUE_WIDTH-1:0] item_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   found,
  output logic [VALUE_WIDTH-1:0] read_value,
  output logic [1:0]             status,
  output logic [OUT_COUNT_W-1:0] item_count
);

  htqp_cmd_t cmd;
  htqp_sts_t sts;

  htqp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  htqp_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .kind       (kind),
    .item_key   (item_key),
    .hash_index (hash_index),
    .item_value (item_value),
    .found      (found),
    .read_value (read_value),
    .status     (status),
    .item_count (item_count)
  );

endmodule

/* src/htqp_ctrl.sv */
// Controller for the quadratic-probe hash table: clear pass, accept, probe
// and commit sequencing, and the result valid flag. Uses htqp_pkg.
module htqp_ctrl import htqp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output htqp_cmd_t cmd,
  input  htqp_sts_t sts
);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_PROBE  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.op_nop ? S_COMMIT : S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.probe_stop) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_valid || !out_stall) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign in_stall       = (state != S_IDLE);
  assign out_valid_next = cmd.commit | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  a_commit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result not flagged after commit");
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("input taken during clear pass");
  a_stop_to_commit: assert property (@(posedge clk) disable iff (rst)
    (cmd.probe && sts.probe_stop) |=> (state == S_COMMIT))
    else $error("probe stop did not reach commit");
`endif

endmodule

/* src/htqp_datapath.sv */
// Datapath for the quadratic-probe hash table: bucket memories, probe address
// walk, probe bookkeeping, counts and result registers. Uses htqp_pkg.
module htqp_datapath import htqp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  htqp_cmd_t              cmd,
  output htqp_sts_t              sts,
  input  logic [1:0]             kind,
  input  logic [KEY_WIDTH-1:0]   item_key,
  input  logic [HASH_W-1:0]      hash_index,
  input  logic [VALUE_WIDTH-1:0] item_value,
  output logic                   found,
  output logic [VALUE_WIDTH-1:0] read_value,
  output logic [1:0]             status,
  output logic [OUT_COUNT_W-1:0] item_count
);

  logic [1:0]             status_mem [TABLE_SIZE];
  logic [KEY_WIDTH-1:0]   key_mem    [TABLE_SIZE];
  logic [VALUE_WIDTH-1:0] value_mem  [TABLE_SIZE];

  logic [1:0]             rd_status;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic [IDX_W-1:0]       rd_addr;

  logic [1:0]             op_kind;
  logic [KEY_WIDTH-1:0]   op_key;
  logic [VALUE_WIDTH-1:0] op_value;

  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       step;
  logic [IDX_W-1:0]       pend_idx;
  logic                   pend_last;
  logic [IDX_W-1:0]       clear_addr;

  logic                   hit;
  logic [IDX_W-1:0]       hit_at;
  logic [VALUE_WIDTH-1:0] hit_value;
  logic                   have_tomb;
  logic [IDX_W-1:0]       tomb_at;
  logic                   have_empty;
  logic [IDX_W-1:0]       empty_at;

  logic [COUNT_W-1:0]     live_count, live_next;
  logic [COUNT_W-1:0]     busy_count, busy_next;

  logic                   st_we;
  logic [IDX_W-1:0]       st_wa;
  logic [1:0]             st_wd;
  logic                   key_we;
  logic                   val_we;
  logic [IDX_W-1:0]       kv_wa;
  logic                   res_found;
  logic [VALUE_WIDTH-1:0] res_value;
  logic [1:0]             res_status;

  logic                   is_empty;
  logic                   is_match;

  assign rd_addr  = cmd.load ? hash_index[IDX_W-1:0] : idx;
  assign is_empty = (rd_status == BKT_EMPTY);
  assign is_match = (rd_status == BKT_USED) && (rd_key == op_key);

  assign sts.clear_last = (clear_addr == IDX_W'(TABLE_SIZE - 1));
  assign sts.probe_stop = is_empty || is_match || pend_last;
  assign sts.op_nop     = (kind == KIND_NOP);

  always_ff @(posedge clk) begin
    if (st_we) status_mem[st_wa] <= st_wd;
    rd_status <= status_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[kv_wa] <= op_key;
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (val_we) value_mem[kv_wa] <= op_value;
    rd_value <= value_mem[rd_addr];
  end

  always_comb begin
    st_we      = 1'b0;
    st_wa      = clear_addr;
    st_wd      = BKT_EMPTY;
    key_we     = 1'b0;
    val_we     = 1'b0;
    kv_wa      = hit_at;
    live_next  = live_count;
    busy_next  = busy_count;
    res_found  = 1'b0;
    res_value  = '0;
    res_status = ST_DONE;
    if (cmd.clear) begin
      st_we = 1'b1;
    end else if (cmd.commit) begin
      unique case (op_kind)
        KIND_INSERT: begin
          if (hit) begin
            val_we = 1'b1;
          end else if (have_tomb) begin
            st_we     = 1'b1;
            st_wa     = tomb_at;
            st_wd     = BKT_USED;
            key_we    = 1'b1;
            val_we    = 1'b1;
            kv_wa     = tomb_at;
            live_next = live_count + 1'b1;
          end else if (have_empty && (busy_count < COUNT_W'(HALF_SIZE))) begin
            st_we     = 1'b1;
            st_wa     = empty_at;
            st_wd     = BKT_USED;
            key_we    = 1'b1;
            val_we    = 1'b1;
            kv_wa     = empty_at;
            live_next = live_count + 1'b1;
            busy_next = busy_count + 1'b1;
          end else begin
            res_status = ST_FULL;
          end
        end
        KIND_LOOKUP: begin
          if (hit) begin
            res_found = 1'b1;
            res_value = hit_value;
          end else begin
            res_status = ST_MISS;
          end
        end
        KIND_REMOVE: begin
          if (hit) begin
            res_found = 1'b1;
            st_we     = 1'b1;
            st_wa     = hit_at;
            st_wd     = BKT_TOMB;
            if (live_count != '0) live_next = live_count - 1'b1;
          end else begin
            res_status = ST_MISS;
          end
        end
        default: res_status = ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
      live_count <= '0;
      busy_count <= '0;
    end else begin
      if (cmd.clear) clear_addr <= clear_addr + 1'b1;
      live_count <= live_next;
      busy_count <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind    <= kind;
      op_key     <= item_key;
      op_value   <= item_value;
      idx        <= hash_index[IDX_W-1:0] + 1'b1;
      step       <= IDX_W'(1);
      pend_idx   <= hash_index[IDX_W-1:0];
      pend_last  <= 1'b0;
      hit        <= 1'b0;
      have_tomb  <= 1'b0;
      have_empty <= 1'b0;
    end else if (cmd.probe) begin
      idx       <= idx + step + 1'b1;
      step      <= step + 1'b1;
      pend_idx  <= idx;
      pend_last <= (step == IDX_W'(TABLE_SIZE - 1));
      if (is_empty) begin
        have_empty <= 1'b1;
        empty_at   <= pend_idx;
      end else if (is_match) begin
        hit       <= 1'b1;
        hit_at    <= pend_idx;
        hit_value <= rd_value;
      end else if ((rd_status == BKT_TOMB) && !have_tomb) begin
        have_tomb <= 1'b1;
        tomb_at   <= pend_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      found      <= res_found;
      read_value <= res_value;
      status     <= res_status;
      item_count <= live_next[OUT_COUNT_W-1:0];
    end
  end

`ifndef SYNTH
  a_live_le_busy: assert property (@(posedge clk) disable iff (rst)
    live_count <= busy_count)
    else $error("live count above busy count");
  a_busy_le_half: assert property (@(posedge clk) disable iff (rst)
    busy_count <= COUNT_W'(HALF_SIZE))
    else $error("busy count above half table");
  a_busy_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (busy_count >= $past(busy_count)))
    else $error("busy count decreased");
`endif

endmodule

/* dv/htqp_table_checker.sv */
// Checker for the quadratic-probe hash table: keeps its own bucket table,
// predicts one reply per accepted item and compares replies field by field.
// Depends on htqp_pkg.
module htqp_table_checker import htqp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [1:0]             kind,
  input  logic [KEY_WIDTH-1:0]   item_key,
  input  logic [HASH_W-1:0]      hash_index,
  input  logic [VALUE_WIDTH-1:0] item_value,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   found,
  input  logic [VALUE_WIDTH-1:0] read_value,
  input  logic [1:0]             status,
  input  logic [OUT_COUNT_W-1:0] item_count,
  output int                     replies_owed,
  output int                     mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                   hit;
    logic [VALUE_WIDTH-1:0] value;
    logic [1:0]             code;
    logic [OUT_COUNT_W-1:0] count;
  } reply_t;

  logic [1:0]             bkt_state [TABLE_SIZE];
  logic [KEY_WIDTH-1:0]   bkt_key   [TABLE_SIZE];
  logic [VALUE_WIDTH-1:0] bkt_val   [TABLE_SIZE];
  int unsigned            live_n;
  int unsigned            busy_n;
  reply_t                 replies_due [$];

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    mismatches = mismatches + 1;
  endtask

  // Walks the triangular probe path, applies the operation to the table
  // and returns the reply it should produce.
  function automatic reply_t predict_table_op(logic [1:0] op, logic [KEY_WIDTH-1:0] key,
                                              logic [HASH_W-1:0] hash,
                                              logic [VALUE_WIDTH-1:0] val);
    reply_t           r;
    int               hit_at;
    int               empty_at;
    int               tomb_at;
    logic [IDX_W-1:0] offs;
    logic [IDX_W-1:0] idx;
    r = '0;
    hit_at = -1;
    empty_at = -1;
    tomb_at = -1;
    offs = '0;
    if (op != KIND_NOP) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        offs = offs + IDX_W'(i);
        idx = hash[IDX_W-1:0] + offs;
        if (bkt_state[idx] == BKT_EMPTY) begin
          empty_at = int'(idx);
          break;
        end
        if (bkt_state[idx] == BKT_TOMB) begin
          if (tomb_at < 0) tomb_at = int'(idx);
        end else if (bkt_key[idx] == key) begin
          hit_at = int'(idx);
          break;
        end
      end
    end
    case (op)
      KIND_INSERT: begin
        if (hit_at >= 0) begin
          bkt_val[hit_at] = val;
        end else if (tomb_at >= 0) begin
          bkt_state[tomb_at] = BKT_USED;
          bkt_key[tomb_at] = key;
          bkt_val[tomb_at] = val;
          live_n++;
        end else if (empty_at >= 0 && busy_n < HALF_SIZE) begin
          bkt_state[empty_at] = BKT_USED;
          bkt_key[empty_at] = key;
          bkt_val[empty_at] = val;
          live_n++;
          busy_n++;
        end else begin
          r.code = ST_FULL;
        end
      end
      KIND_LOOKUP: begin
        if (hit_at >= 0) begin
          r.hit = 1'b1;
          r.value = bkt_val[hit_at];
        end else begin
          r.code = ST_MISS;
        end
      end
      KIND_REMOVE: begin
        if (hit_at >= 0) begin
          r.hit = 1'b1;
          bkt_state[hit_at] = BKT_TOMB;
          bkt_val[hit_at] = '0;
          if (live_n > 0) live_n--;
        end else begin
          r.code = ST_MISS;
        end
      end
      default: ;
    endcase
    r.count = OUT_COUNT_W'(live_n);
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      foreach (bkt_state[j]) bkt_state[j] = BKT_EMPTY;
      live_n = 0;
      busy_n = 0;
      replies_due.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (replies_due.size() == 0) begin
          report_mismatch("reply with no item pending", read_value, '0);
        end else begin
          want = replies_due.pop_front();
          if (found !== want.hit) report_mismatch("found", found, want.hit);
          if (read_value !== want.value) report_mismatch("read_value", read_value, want.value);
          if (status !== want.code) report_mismatch("status", status, want.code);
          if (item_count !== want.count) report_mismatch("item_count", item_count, want.count);
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        replies_due.push_back(predict_table_op(kind, item_key, hash_index, item_value));
      end
    end
    replies_owed <= replies_due.size();
  end

endmodule

/* dv/tb_hash_table_quadratic_probe_unit.sv */
// Testbench top for the quadratic-probe hash table: clock, reset, item
// stimulus and output stall, plus the verdict. Depends on htqp_pkg,
// htqp_table_checker and hash_table_quadratic_probe_unit.
module tb_hash_table_quadratic_probe_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import htqp_pkg::*;

  localparam int QUIET_LIMIT = 8000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [KEY_WIDTH-1:0] k;
    logic [HASH_W-1:0]    h;
  } known_key_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             kind = KIND_NOP;
  logic [KEY_WIDTH-1:0]   item_key = '0;
  logic [HASH_W-1:0]      hash_index = '0;
  logic [VALUE_WIDTH-1:0] item_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   found;
  logic [VALUE_WIDTH-1:0] read_value;
  logic [1:0]             status;
  logic [OUT_COUNT_W-1:0] item_count;
  int                     replies_owed;
  int                     mismatches;

  int         tx_idle = 32;
  int         rx_idle = 59;
  logic       hold_req = 1'b0;
  logic       hold_done = 1'b0;
  int         hold_left = 0;
  known_key_t known_keys [$];

  always #5 clk = ~clk;

  hash_table_quadratic_probe_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .item_key   (item_key),
    .hash_index (hash_index),
    .item_value (item_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .read_value (read_value),
    .status     (status),
    .item_count (item_count)
  );

  htqp_table_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .item_key     (item_key),
    .hash_index   (hash_index),
    .item_value   (item_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .read_value   (read_value),
    .status       (status),
    .item_count   (item_count),
    .replies_owed (replies_owed),
    .mismatches   (mismatches)
  );

  // receiver: random stall, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      hold_left <= 0;
      out_stall <= ($urandom_range(0, 99) < rx_idle);
    end
  end

  task automatic send_item(logic [1:0] op, logic [KEY_WIDTH-1:0] k, logic [HASH_W-1:0] h,
                           logic [VALUE_WIDTH-1:0] v);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= op;
    item_key   <= k;
    hash_index <= h;
    item_value <= v;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (replies_owed != 0);
  endtask

  // a mix of inserts of new keys and operations on keys already offered, with some clustering of homes
  task automatic random_item(int new_pct, int near_pct);
    int unsigned            r;
    logic [KEY_WIDTH-1:0]   k;
    logic [HASH_W-1:0]      h;
    logic [1:0]             op;
    known_key_t             pick;
    k = $urandom;
    h = $urandom;
    if ($urandom_range(0, 99) < near_pct) h[IDX_W-1:0] = IDX_W'($urandom_range(0, 63));
    r = $urandom_range(0, 99);
    if (known_keys.size() == 0 || $urandom_range(0, 99) < new_pct) begin
      op = KIND_INSERT;
      known_keys.push_back('{k, h});
    end else if (r < 80) begin
      pick = known_keys[$urandom_range(0, known_keys.size() - 1)];
      k = pick.k;
      if ($urandom_range(0, 9) != 0) h = pick.h;
      op = (r < 15) ? KIND_INSERT : (r < 55) ? KIND_LOOKUP : KIND_REMOVE;
    end else begin
      op = (r < 88) ? KIND_LOOKUP : (r < 95) ? KIND_REMOVE : KIND_NOP;
    end
    send_item(op, k, h, $urandom);
  endtask

  task automatic run_mix(int n, int new_pct, int near_pct, int hold_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_req <= 1'b1;
      random_item(new_pct, near_pct);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // keys 0, 1, 2 share home bucket 0; all-ones key lives at the top bucket
    send_item(KIND_LOOKUP, 32'h0, 32'h0, 32'h0);
    send_item(KIND_INSERT, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_item(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_item(KIND_INSERT, 32'h1, 32'h0000_0400, 32'h1234_5678);
    send_item(KIND_INSERT, 32'h2, 32'hFFFF_FC00, 32'hA5A5_A5A5);
    send_item(KIND_LOOKUP, 32'h2, 32'h0, 32'h0);
    send_item(KIND_LOOKUP, 32'h1, 32'h0, 32'hFFFF_FFFF);
    send_item(KIND_INSERT, 32'h1, 32'h0, 32'h5A5A_5A5A);
    send_item(KIND_LOOKUP, 32'h1, 32'h0, 32'h0);
    send_item(KIND_REMOVE, 32'h1, 32'h0, 32'h0);
    send_item(KIND_LOOKUP, 32'h1, 32'h0, 32'h0);
    send_item(KIND_LOOKUP, 32'h2, 32'h0, 32'h0);
    send_item(KIND_INSERT, 32'h3, 32'h0, 32'h1);
    send_item(KIND_REMOVE, 32'h7, 32'h0, 32'h0);
    send_item(KIND_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_item(KIND_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_item(KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_03FF, 32'h8000_0000);
    send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_item(KIND_LOOKUP, 32'h0, 32'h0000_0400, 32'h0);
    send_item(KIND_LOOKUP, 32'h0, 32'h1, 32'h0);
    send_item(KIND_REMOVE, 32'h0, 32'h0, 32'h0);
    send_item(KIND_NOP, 32'h0, 32'h0, 32'h0);

    run_mix(260, 45, 40, 100);
    in_valid <= 1'b0;
    wait_drained();

    tx_idle = 59;
    rx_idle = 32;
    run_mix(260, 45, 40, -1);

    // no idling; offer more new keys than half the table holds so inserts get refused
    tx_idle = 0;
    rx_idle = 0;
    run_mix(420, 95, 10, -1);
    in_valid <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_hash_table_quadratic_probe_unit OK");
    end else begin
      $display("tb_hash_table_quadratic_probe_unit NOT OK");
    end
    $finish;
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
    $display("tb_hash_table_quadratic_probe_unit NOT OK");
    $finish;
  end

endmodule
